>>> hw/rtl/oaie_pkg.sv
// Shared constants, operation codes and cell command types for the ordered array.
package oaie_pkg;

    // Array geometry
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Width that holds both a position and a count for compares
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_APPEND     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ERASE      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ_AT    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ_FRONT = 3'd6;
    localparam logic [FUNC_W-1:0] FN_READ_BACK  = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Per-cycle action broadcast to every cell
    typedef enum logic [1:0] {
        CK_NONE,
        CK_WRITE,
        CK_INSERT,
        CK_ERASE
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [IDX_W-1:0]    pos;
        logic [DATA_W-1:0]   value;
        logic [IDX_W-1:0]    rd_pos;
    } t_cell_cmd;

endpackage

>>> hw/rtl/oaie_cell.sv
// One storage cell of the array: holds a word and trades it with its neighbors.
module oaie_cell (
    input  logic                      i_clk,
    input  logic [oaie_pkg::IDX_W-1:0]  i_index,
    input  oaie_pkg::t_cell_cmd       i_cmd,
    input  logic [oaie_pkg::DATA_W-1:0] i_left_data,
    input  logic [oaie_pkg::DATA_W-1:0] i_right_data,
    output logic [oaie_pkg::DATA_W-1:0] o_data,
    output logic [oaie_pkg::DATA_W-1:0] o_read
);
    import oaie_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // Pick the next word: load, take from a neighbor, or hold
    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            CK_WRITE: begin
                if (i_index == i_cmd.pos) n_data = i_cmd.value;
            end
            CK_INSERT: begin
                if (i_index == i_cmd.pos)     n_data = i_cmd.value;
                else if (i_index > i_cmd.pos) n_data = i_left_data;
            end
            CK_ERASE: begin
                if (i_index >= i_cmd.pos) n_data = i_right_data;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Drive the shared read bus only when addressed
    assign o_read = (i_index == i_cmd.rd_pos) ? r_data : '0;

endmodule

>>> hw/rtl/ordered_array_insert_erase.sv
// Top level of the ordered word array with insert and erase over a row of cells.
//
// Usage: each input transfer on i_valid/o_ready carries one operation (func,
// position, element_value). Every operation returns exactly one result transfer
// on o_valid/i_ready: read_value, element_count, is_empty and status.
// Insert and erase move all later words one place at once: every cell
// takes its neighbor's word at the transfer edge, so no operation iterates.
// The result is registered: it is valid in the cycle after the input transfer.
// Throughput: one operation per cycle while the receiver takes each result; the
// decode, the count compares and the OR-combined read bus across the cells set the cycle.
// A single output register separates the two sides: a new input is taken in the
// same cycle the held result is taken, or whenever no result is waiting. While
// the receiver stalls, the result holds and o_ready stays low, so no input is taken.
// Reset empties the array (count zero, no result pending); stored words are not
// cleared, as entries at or above the count are never read.
module ordered_array_insert_erase (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [oaie_pkg::FUNC_W-1:0]   i_func,
    input  logic [oaie_pkg::POS_W-1:0]    i_position,
    input  logic [oaie_pkg::VALUE_W-1:0]  i_element_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [oaie_pkg::VALUE_W-1:0]  o_read_value,
    output logic [oaie_pkg::COUNT_W-1:0]  o_element_count,
    output logic                          o_is_empty,
    output logic [oaie_pkg::STATUS_W-1:0] o_status
);
    import oaie_pkg::*;

    logic                 r_valid;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [DATA_W-1:0]    r_read;
    logic [DATA_W-1:0]    n_read;
    logic [STATUS_W-1:0]  r_status;
    logic [STATUS_W-1:0]  n_status;
    logic                 w_accept;
    logic                 w_is_read;
    logic [CMP_W-1:0]     w_pos;
    logic [CMP_W-1:0]     w_cnt;
    logic                 w_full;
    t_cell_cmd            w_cmd;
    logic [DATA_W-1:0]    w_cell_data [CAPACITY];
    logic [DATA_W-1:0]    w_cell_read [CAPACITY];
    logic [DATA_W-1:0]    w_read_bus;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_pos    = CMP_W'(i_position);
    assign w_cnt    = CMP_W'(r_count);
    assign w_full   = (r_count == CNT_W'(CAPACITY));

    // Decode the operation into a cell command, next count and status
    always_comb begin
        w_cmd.op     = CK_NONE;
        w_cmd.pos    = IDX_W'(i_position);
        w_cmd.value  = DATA_W'(i_element_value);
        w_cmd.rd_pos = IDX_W'(i_position);
        n_count      = r_count;
        n_status     = ST_OK;
        w_is_read    = 1'b0;
        unique case (i_func)
            FN_APPEND: begin
                w_cmd.pos = IDX_W'(r_count);
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.op = CK_WRITE;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            FN_REMOVE: begin
                if (r_count != '0) n_count = r_count - CNT_W'(1);
            end
            FN_INSERT: begin
                if (w_pos > w_cnt) begin
                    n_status = ST_RANGE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.op = CK_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            FN_ERASE: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_cmd.op = CK_ERASE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            FN_READ_AT: begin
                if (w_pos >= w_cnt) n_status = ST_RANGE;
                else                w_is_read = 1'b1;
            end
            FN_CLEAR: begin
                n_count = '0;
            end
            FN_READ_FRONT: begin
                w_cmd.rd_pos = '0;
                if (r_count == '0) n_status = ST_RANGE;
                else               w_is_read = 1'b1;
            end
            FN_READ_BACK: begin
                w_cmd.rd_pos = IDX_W'(r_count - CNT_W'(1));
                if (r_count == '0) n_status = ST_RANGE;
                else               w_is_read = 1'b1;
            end
            default: n_status = ST_OK;
        endcase
        // Cells move only on a transfer
        if (!w_accept) w_cmd.op = CK_NONE;
    end

    // Build the row of cells; the last cell pulls zero on erase
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end
        oaie_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_cmd        (w_cmd),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .o_data       (w_cell_data[g]),
            .o_read       (w_cell_read[g])
        );
    end

    // Combine the addressed cell's word
    always_comb begin
        w_read_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_read_bus = w_read_bus | w_cell_read[k];
        end
    end

    assign n_read = w_is_read ? w_read_bus : '0;

    // Advance count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read   <= n_read;
            r_status <= n_status;
        end
    end

    assign o_valid         = r_valid;
    assign o_read_value    = VALUE_W'(r_read);
    assign o_element_count = COUNT_W'(r_count);
    assign o_is_empty      = (r_count == '0);
    assign o_status        = r_status;

endmodule
